### src/thc_pkg.sv
`timescale 1ns / 1ps

package thc_pkg;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [19:0] TEMP_SKIP_CODE = 20'd524288;
	localparam logic [15:0] HUM_SKIP_CODE  = 16'd32768;
	localparam logic [31:0] FINE_OFFSET    = 32'd76800;
	localparam logic [31:0] HUM_ROUND_A    = 32'd16384;
	localparam logic [31:0] HUM_C_BIAS     = 32'd32768;
	localparam logic [31:0] HUM_D_BIAS     = 32'd2097152;
	localparam logic [31:0] HUM_ROUND_E    = 32'd8192;
	localparam logic [31:0] HUM_MAX_RAW    = 32'd419430400;
	localparam logic [31:0] TEMP_ROUND     = 32'd128;
	localparam logic [31:0] TEMP_SCALE     = 32'd5;

	// configuration register map
	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_TEMP_COEF_ONE      = 3'd0,
		REG_TEMP_COEF_TWO      = 3'd1,
		REG_TEMP_COEF_THREE    = 3'd2,
		REG_HUM_COEF_ONE       = 3'd3,
		REG_HUM_COEF_TWO       = 3'd4,
		REG_HUM_COEF_THREE     = 3'd5,
		REG_HUM_COEF_FOUR_FIVE = 3'd6,
		REG_HUM_COEF_SIX       = 3'd7
	} cfg_reg_t;

	// one multiply step of the compensation sequence, in execution order
	typedef enum logic [3:0] {
		OP_V1   = 4'd0,
		OP_D2SQ = 4'd1,
		OP_V2   = 4'd2,
		OP_TC   = 4'd3,
		OP_A    = 4'd4,
		OP_B    = 4'd5,
		OP_C    = 4'd6,
		OP_D    = 4'd7,
		OP_E    = 4'd8,
		OP_X    = 4'd9,
		OP_SS   = 4'd10,
		OP_H1   = 4'd11
	} op_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic post;
		logic store;
		op_t  op;
	} ctrl_cmd_t;

	typedef struct packed {
		logic skip_t;
		logic skip_h;
		logic hum_pending;
	} dp_stat_t;

endpackage

### src/thc_if.sv
`timescale 1ns / 1ps

interface thc_in_if;
	logic        valid;
	logic        ready;
	logic [19:0] raw_temp;
	logic [15:0] raw_hum;

	modport source (output valid, output raw_temp, output raw_hum, input ready);
	modport sink (input valid, input raw_temp, input raw_hum, output ready);
endinterface

interface thc_out_if;
	logic               valid;
	logic               ready;
	logic signed [24:0] temp_centi;
	logic               temp_ok;
	logic        [16:0] hum_q10;
	logic               hum_ok;

	modport source (output valid, output temp_centi, output temp_ok, output hum_q10,
		output hum_ok, input ready);
	modport sink (input valid, input temp_centi, input temp_ok, input hum_q10,
		input hum_ok, output ready);
endinterface

### src/temp_humidity_compensation_core.sv
`timescale 1ns / 1ps

// Temperature / humidity compensation core.
// in_ch carries one raw temperature sample and one raw humidity sample per
// transfer; out_ch returns temperature in 0.01 degC and humidity in 1/1024 %RH
// with a valid flag for each. A sample equal to its skip code yields a zero
// value with its flag low; a skipped temperature keeps the last fine
// temperature, which the humidity path then uses.
// The user writes calibration words through cfg_we / cfg_addr / cfg_data only
// while no item is in flight; the block itself does not enforce this. All of
// them and the fine temperature reset to zero. One shared 32x32 multiplier does
// every product (multiply, then shift/add into the destination register). An
// item with both samples valid runs one load step, four temperature and eight
// humidity products and one store step. A skipped temperature runs no
// temperature products, a skipped humidity no humidity products.
// in_ch.ready is high only while the sequencer is idle; one item is worked on
// at a time. The result sits in an output register, so the next item is
// accepted while out_ch stalls; a finished item waits in the sequencer until
// the output register is free. Reset clears all control state.
module temp_humidity_compensation_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [thc_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [thc_pkg::CFG_DATA_W-1:0] cfg_data,
	thc_in_if.sink                         in_ch,
	thc_out_if.source                      out_ch
);
	import thc_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	thc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	thc_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_data   (cfg_data),
		.raw_temp   (in_ch.raw_temp),
		.raw_hum    (in_ch.raw_hum),
		.cmd        (cmd),
		.stat       (stat),
		.temp_centi (out_ch.temp_centi),
		.temp_ok    (out_ch.temp_ok),
		.hum_q10    (out_ch.hum_q10),
		.hum_ok     (out_ch.hum_ok)
	);

endmodule

### src/thc_dp.sv
`timescale 1ns / 1ps

module thc_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [thc_pkg::CFG_ADDR_W-1:0]        cfg_addr,
	input  logic [thc_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic [19:0]                           raw_temp,
	input  logic [15:0]                           raw_hum,
	input  thc_pkg::ctrl_cmd_t                    cmd,
	output thc_pkg::dp_stat_t                     stat,
	output logic signed [24:0]                    temp_centi,
	output logic                                  temp_ok,
	output logic [16:0]                           hum_q10,
	output logic                                  hum_ok
);
	import thc_pkg::*;

	// calibration registers
	logic [15:0] t1_q, t2_q, t3_q, h2_q;
	logic [7:0]  h1_q, h3_q, h6_q;
	logic [23:0] h45_q;

	logic [31:0] fine_q;

	// working registers
	logic [15:0] rh_q;
	logic        tok_q, hok_q;
	logic [31:0] d1_q, d2_q, v1_q, tmp_q, x_q;
	logic [31:0] a_q, b_q, c_q, d_q, e_q, xh_q, s_q;
	logic [24:0] tc_q;
	logic [16:0] hq_q;
	logic [31:0] p_q;

	logic [31:0] opa, opb;
	logic [31:0] prod;

	logic [31:0] t2_x, t3_x, h2_x, h5_x, h6_x;
	logic signed [31:0] ps, nf, tcs, tcsh, ta, te, fin;
	// sign-filling shifts of the product, kept apart from unsigned operands
	logic signed [31:0] ps_sh4, ps_sh10, ps_sh11, ps_sh14;
	logic [31:0] clamped;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t1_q  <= '0;
			t2_q  <= '0;
			t3_q  <= '0;
			h1_q  <= '0;
			h2_q  <= '0;
			h3_q  <= '0;
			h45_q <= '0;
			h6_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_TEMP_COEF_ONE:      t1_q  <= cfg_data[15:0];
				REG_TEMP_COEF_TWO:      t2_q  <= cfg_data[15:0];
				REG_TEMP_COEF_THREE:    t3_q  <= cfg_data[15:0];
				REG_HUM_COEF_ONE:       h1_q  <= cfg_data[7:0];
				REG_HUM_COEF_TWO:       h2_q  <= cfg_data[15:0];
				REG_HUM_COEF_THREE:     h3_q  <= cfg_data[7:0];
				REG_HUM_COEF_FOUR_FIVE: h45_q <= cfg_data;
				REG_HUM_COEF_SIX:       h6_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign t2_x = {{16{t2_q[15]}}, t2_q};
	assign t3_x = {{16{t3_q[15]}}, t3_q};
	assign h2_x = {{16{h2_q[15]}}, h2_q};
	assign h5_x = {{20{h45_q[23]}}, h45_q[23:12]};
	assign h6_x = {{24{h6_q[7]}}, h6_q};

	assign stat.skip_t      = (raw_temp == TEMP_SKIP_CODE);
	assign stat.skip_h      = (raw_hum == HUM_SKIP_CODE);
	assign stat.hum_pending = hok_q;

	// shared multiplier operand select
	always_comb begin
		case (cmd.op)
			OP_V1:   begin opa = d1_q;  opb = t2_x; end
			OP_D2SQ: begin opa = d2_q;  opb = d2_q; end
			OP_V2:   begin opa = tmp_q; opb = t3_x; end
			OP_TC:   begin opa = fine_q; opb = TEMP_SCALE; end
			OP_A:    begin opa = h5_x;  opb = x_q; end
			OP_B:    begin opa = x_q;   opb = h6_x; end
			OP_C:    begin opa = x_q;   opb = {24'd0, h3_q}; end
			OP_D:    begin opa = b_q;   opb = c_q; end
			OP_E:    begin opa = d_q;   opb = h2_x; end
			OP_X:    begin opa = a_q;   opb = e_q; end
			OP_SS:   begin opa = s_q;   opb = s_q; end
			OP_H1:   begin opa = tmp_q; opb = {24'd0, h1_q}; end
			default: begin opa = '0;    opb = '0; end
		endcase
	end

	// only the low 32 bits of each product are kept
	assign prod = opa * opb;

	// post-processing of the registered product; all arithmetic wraps at 32 bits
	assign ps      = p_q;
	assign ps_sh4  = ps >>> 4;
	assign ps_sh10 = ps >>> 10;
	assign ps_sh11 = ps >>> 11;
	assign ps_sh14 = ps >>> 14;
	assign nf      = v1_q + ps_sh14;
	assign tcs     = ps + TEMP_ROUND;
	assign tcsh    = tcs >>> 8;
	assign ta      = {2'b00, rh_q, 14'd0} - {h45_q[11:0], 20'd0} - p_q + HUM_ROUND_A;
	assign te      = ps + HUM_ROUND_E;
	assign fin     = xh_q - ps_sh4;

	always_comb begin
		if (fin[31])
			clamped = '0;
		else if (fin > HUM_MAX_RAW)
			clamped = HUM_MAX_RAW;
		else
			clamped = fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fine_q <= '0;
		end else if (cmd.post && cmd.op == OP_V2) begin
			fine_q <= nf;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rh_q  <= raw_hum;
			tok_q <= !stat.skip_t;
			hok_q <= !stat.skip_h;
			d1_q  <= {15'd0, raw_temp[19:3]} - {15'd0, t1_q, 1'b0};
			d2_q  <= {16'd0, raw_temp[19:4]} - {16'd0, t1_q};
			x_q   <= fine_q - FINE_OFFSET;
			tc_q  <= '0;
			hq_q  <= '0;
		end
		if (cmd.mul)
			p_q <= prod;
		if (cmd.post) begin
			case (cmd.op)
				OP_V1:   v1_q <= ps_sh11;
				OP_D2SQ: tmp_q <= ps >>> 12;
				OP_V2:   x_q <= nf - FINE_OFFSET;
				OP_TC:   tc_q <= tcsh[24:0];
				OP_A:    a_q <= ta >>> 15;
				OP_B:    b_q <= ps_sh10;
				OP_C:    c_q <= ps_sh11 + HUM_C_BIAS;
				OP_D:    d_q <= ps_sh10 + HUM_D_BIAS;
				OP_E:    e_q <= te >>> 14;
				OP_X:    begin
					xh_q <= p_q;
					s_q  <= ps >>> 15;
				end
				OP_SS:   tmp_q <= ps >>> 7;
				OP_H1:   hq_q <= clamped[28:12];
				default: ;
			endcase
		end
		if (cmd.store) begin
			temp_centi <= tc_q;
			temp_ok    <= tok_q;
			hum_q10    <= hq_q;
			hum_ok     <= hok_q;
		end
	end

endmodule

### src/thc_ctrl.sv
`timescale 1ns / 1ps

module thc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  thc_pkg::dp_stat_t  stat,
	output thc_pkg::ctrl_cmd_t cmd
);
	import thc_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_POST = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t state_q, state_d;
	op_t    op_q, op_d;
	logic   out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d   = state_q;
		op_d      = op_q;
		cmd.load  = 1'b0;
		cmd.mul   = 1'b0;
		cmd.post  = 1'b0;
		cmd.store = 1'b0;
		cmd.op    = op_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (!stat.skip_t) begin
						op_d    = OP_V1;
						state_d = ST_MUL;
					end else if (!stat.skip_h) begin
						op_d    = OP_A;
						state_d = ST_MUL;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_POST;
			end
			ST_POST: begin
				cmd.post = 1'b1;
				case (op_q)
					OP_TC: begin
						if (stat.hum_pending) begin
							op_d    = OP_A;
							state_d = ST_MUL;
						end else begin
							state_d = ST_DONE;
						end
					end
					OP_H1:   state_d = ST_DONE;
					default: begin
						op_d    = op_t'(op_q + 4'd1);
						state_d = ST_MUL;
					end
				endcase
			end
			ST_DONE: begin
				// result register frees up in the same cycle as its transfer
				if (!out_valid_q || out_ready) begin
					cmd.store = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_V1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			if (cmd.store)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	a_mul_then_post: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL |=> state_q == ST_POST && op_q == $past(op_q))
		else $error("multiply step not followed by its post step");

	a_last_op_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_POST && op_q == OP_H1 |=> state_q == ST_DONE)
		else $error("humidity sequence did not finish");

	a_store_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store |=> out_valid_q)
		else $error("stored result not presented");

	a_load_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q != ST_IDLE)
		else $error("accepted item dropped");

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import thc_pkg::*;

	localparam logic [19:0] T_SKIP       = 20'd524288;
	localparam logic [15:0] H_SKIP       = 16'd32768;
	localparam logic [31:0] T_FINE_OFS   = 32'd76800;
	localparam logic [31:0] T_MUL        = 32'd5;
	localparam logic [31:0] T_RND        = 32'd128;
	localparam logic [31:0] H_RND_A      = 32'd16384;
	localparam logic [31:0] H_BIAS_C     = 32'd32768;
	localparam logic [31:0] H_BIAS_D     = 32'd2097152;
	localparam logic [31:0] H_RND_E      = 32'd8192;
	localparam logic [31:0] H_CLAMP      = 32'd419430400;
	localparam logic [16:0] H_Q10_MAX    = 17'd102400;
	localparam int          PHASE_ITEMS  = 200;
	localparam int          JITTER_SETS  = 3;
	localparam int          RANDOM_SETS  = 3;
	localparam int          WATCHDOG_MAX = 5000;
	localparam int          DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [19:0] raw_temp;
		logic [15:0] raw_hum;
	} sample_t;

	typedef struct packed {
		logic signed [24:0] temp_centi;
		logic               temp_ok;
		logic        [16:0] hum_q10;
		logic               hum_ok;
	} reading_t;

	typedef logic [CFG_DATA_W-1:0] coef_words_t [8];
	typedef enum logic [1:0] {RX_FLOW, RX_COIN, RX_CHOKE} rx_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_data;

	thc_in_if  in_ch();
	thc_out_if out_ch();

	temp_humidity_compensation_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	always #1 clk = ~clk;

	// calibration shadow and fine temperature as the block should hold them
	logic [15:0] cal_t1, cal_t2, cal_t3, cal_h2;
	logic [7:0]  cal_h1, cal_h3, cal_h6;
	logic [23:0] cal_h45;
	logic [31:0] fine_temp_q;

	sample_t  sample_q[$];
	reading_t reading_q[$];

	int n_mismatch = 0;
	int n_samples = 0;
	int n_readings = 0;
	int n_t_skip = 0;
	int n_h_skip = 0;
	int n_h_floor = 0;
	int n_h_ceil = 0;
	int n_cal_sets = 0;
	int idle_cycles = 0;
	int burst_left;
	int gap_left;
	int rx_left;
	rx_mode_t rx_mode;

	function automatic logic [31:0] sar32(input logic [31:0] v, input int n);
		return $signed(v) >>> n;
	endfunction

	// integer compensation; updates fine_temp_q unless the temperature was skipped
	function automatic reading_t compensate(input sample_t s);
		logic [31:0] t1, t2, t3, d1, v1, d2, v2, tc;
		logic [31:0] h2, h4, h5, h6, x, a, b, c, d, e, sq;
		reading_t r;
		r = '0;
		if (s.raw_temp != T_SKIP) begin
			t1 = {16'd0, cal_t1};
			t2 = {{16{cal_t2[15]}}, cal_t2};
			t3 = {{16{cal_t3[15]}}, cal_t3};
			d1 = {15'd0, s.raw_temp[19:3]} - (t1 << 1);
			v1 = sar32(d1 * t2, 11);
			d2 = {16'd0, s.raw_temp[19:4]} - t1;
			v2 = sar32(sar32(d2 * d2, 12) * t3, 14);
			fine_temp_q = v1 + v2;
			tc = sar32(fine_temp_q * T_MUL + T_RND, 8);
			r.temp_centi = tc[24:0];
			r.temp_ok = 1'b1;
		end
		if (s.raw_hum != H_SKIP) begin
			h2 = {{16{cal_h2[15]}}, cal_h2};
			h4 = {{20{cal_h45[11]}}, cal_h45[11:0]};
			h5 = {{20{cal_h45[23]}}, cal_h45[23:12]};
			h6 = {{24{cal_h6[7]}}, cal_h6};
			x = fine_temp_q - T_FINE_OFS;
			a = sar32(({16'd0, s.raw_hum} << 14) - (h4 << 20) - (h5 * x) + H_RND_A, 15);
			b = sar32(x * h6, 10);
			c = sar32(x * {24'd0, cal_h3}, 11) + H_BIAS_C;
			d = sar32(b * c, 10) + H_BIAS_D;
			e = sar32(d * h2 + H_RND_E, 14);
			x = a * e;
			sq = sar32(x, 15);
			x = x - sar32(sar32(sq * sq, 7) * {24'd0, cal_h1}, 4);
			if (x[31])
				x = '0;
			else if (x > H_CLAMP)
				x = H_CLAMP;
			r.hum_q10 = x[28:12];
			r.hum_ok = 1'b1;
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
			n_mismatch++;
		end
	endtask

	function automatic sample_t pick_sample();
		sample_t s;
		int pt, ph;
		pt = $urandom_range(0, 99);
		ph = $urandom_range(0, 99);
		s.raw_temp = 20'($urandom_range(0, 20'hFFFFF));
		s.raw_hum = 16'($urandom_range(0, 16'hFFFF));
		if (pt < 5)
			s.raw_temp = T_SKIP;
		else if (pt < 12)
			case ($urandom_range(0, 3))
				0: s.raw_temp = '0;
				1: s.raw_temp = '1;
				2: s.raw_temp = T_SKIP - 20'd1;
				default: s.raw_temp = T_SKIP + 20'd1;
			endcase
		else if (pt < 65)
			s.raw_temp = 20'($urandom_range(400000, 620000));
		if (ph < 5)
			s.raw_hum = H_SKIP;
		else if (ph < 12)
			case ($urandom_range(0, 3))
				0: s.raw_hum = '0;
				1: s.raw_hum = '1;
				2: s.raw_hum = H_SKIP - 16'd1;
				default: s.raw_hum = H_SKIP + 16'd1;
			endcase
		else if (ph < 65)
			s.raw_hum = 16'($urandom_range(15000, 50000));
		return s;
	endfunction

	task automatic queue_samples(input int n);
		for (int i = 0; i < n; i++)
			sample_q.push_back(pick_sample());
	endtask

	task automatic queue_directed();
		sample_q.push_back('{20'd519888, 16'd30000});
		// skipped temperature: humidity runs on the held fine temperature
		sample_q.push_back('{T_SKIP, 16'd30000});
		sample_q.push_back('{T_SKIP, 16'd45000});
		sample_q.push_back('{20'd519888, H_SKIP});
		sample_q.push_back('{T_SKIP, H_SKIP});
		sample_q.push_back('{20'd0, 16'd0});
		sample_q.push_back('{20'hFFFFF, 16'hFFFF});
		sample_q.push_back('{20'd0, 16'hFFFF});
		sample_q.push_back('{20'hFFFFF, 16'd0});
		sample_q.push_back('{T_SKIP - 20'd1, H_SKIP - 16'd1});
		sample_q.push_back('{T_SKIP + 20'd1, H_SKIP + 16'd1});
		sample_q.push_back('{T_SKIP, 16'd0});
		sample_q.push_back('{T_SKIP, 16'hFFFF});
		sample_q.push_back('{20'h55555, 16'hAAAA});
		sample_q.push_back('{20'hAAAAA, 16'h5555});
		sample_q.push_back('{20'd415000, 16'd20000});
		sample_q.push_back('{20'd600000, 16'd45000});
		// drive humidity into both clamps
		sample_q.push_back('{20'd540000, 16'd62000});
		sample_q.push_back('{20'd540000, 16'd5000});
	endtask

	task automatic program_coefs(input coef_words_t w);
		for (int i = 0; i < 8; i++) begin
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_addr <= cfg_reg_t'(i);
			cfg_data <= w[i];
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		n_cal_sets++;
	endtask

	// block drained and nothing outstanding
	task automatic settle();
		while (!(sample_q.size() == 0 && !in_ch.valid && reading_q.size() == 0))
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [CFG_DATA_W-1:0] jitter(input int base, input int span);
		return CFG_DATA_W'(base + $urandom_range(0, 2 * span) - span);
	endfunction

	// sample source: bursts of transfers separated by random gaps
	always @(posedge clk) begin : src
		sample_t nxt;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.raw_temp <= '0;
			in_ch.raw_hum <= '0;
			burst_left = 0;
			gap_left = 0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (gap_left > 0) begin
				gap_left--;
				in_ch.valid <= 1'b0;
			end else if (sample_q.size() > 0) begin
				nxt = sample_q.pop_front();
				in_ch.valid <= 1'b1;
				in_ch.raw_temp <= nxt.raw_temp;
				in_ch.raw_hum <= nxt.raw_hum;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 12);
					gap_left = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 40);
				end
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// result sink: stall mode is redrawn at random among flowing, coin-toss and choked ready
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			rx_left = 0;
			rx_mode = RX_FLOW;
		end else begin
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 2));
				rx_left = $urandom_range(16, 400);
			end else begin
				rx_left--;
			end
			case (rx_mode)
				RX_FLOW: out_ch.ready <= 1'b1;
				RX_COIN: out_ch.ready <= 1'($urandom_range(0, 1));
				default: out_ch.ready <= ($urandom_range(0, 11) == 0);
			endcase
		end
	end

	// tracks register writes, predicts on input transfers, checks output transfers
	always @(posedge clk) begin : mon
		reading_t want;
		if (!arst_n) begin
			cal_t1 = '0;
			cal_t2 = '0;
			cal_t3 = '0;
			cal_h1 = '0;
			cal_h2 = '0;
			cal_h3 = '0;
			cal_h45 = '0;
			cal_h6 = '0;
			fine_temp_q = '0;
		end else begin
			if (cfg_we)
				case (cfg_reg_t'(cfg_addr))
					REG_TEMP_COEF_ONE:      cal_t1 = cfg_data[15:0];
					REG_TEMP_COEF_TWO:      cal_t2 = cfg_data[15:0];
					REG_TEMP_COEF_THREE:    cal_t3 = cfg_data[15:0];
					REG_HUM_COEF_ONE:       cal_h1 = cfg_data[7:0];
					REG_HUM_COEF_TWO:       cal_h2 = cfg_data[15:0];
					REG_HUM_COEF_THREE:     cal_h3 = cfg_data[7:0];
					REG_HUM_COEF_FOUR_FIVE: cal_h45 = cfg_data[23:0];
					REG_HUM_COEF_SIX:       cal_h6 = cfg_data[7:0];
					default: ;
				endcase
			if (out_ch.valid && out_ch.ready) begin
				if (reading_q.size() == 0) begin
					$display("%0t: unexpected transfer, expected none actual temp %0d hum %0d",
						$time, out_ch.temp_centi, out_ch.hum_q10);
					n_mismatch++;
				end else begin
					want = reading_q.pop_front();
					check_field("temp_centi", want.temp_centi, out_ch.temp_centi);
					check_field("temp_ok", want.temp_ok, out_ch.temp_ok);
					check_field("hum_q10", want.hum_q10, out_ch.hum_q10);
					check_field("hum_ok", want.hum_ok, out_ch.hum_ok);
					n_readings++;
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				want = compensate('{in_ch.raw_temp, in_ch.raw_hum});
				reading_q.push_back(want);
				n_samples++;
				if (!want.temp_ok)
					n_t_skip++;
				if (!want.hum_ok)
					n_h_skip++;
				else if (want.hum_q10 == '0)
					n_h_floor++;
				else if (want.hum_q10 == H_Q10_MAX)
					n_h_ceil++;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_MAX) begin
			$display("%0t: no transfer for %0d cycles, %0d readings outstanding",
				$time, idle_cycles, reading_q.size());
			$display("tb_top: FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		coef_words_t cal;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.raw_temp = '0;
		in_ch.raw_hum = '0;
		out_ch.ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// calibration still all zero from reset
		queue_samples(PHASE_ITEMS);
		settle();

		// typical factory calibration
		cal = '{24'd27504, 24'd26435, 24'h00FC18, 24'd75, 24'd362, 24'd0,
			{12'd50, 12'd313}, 24'd30};
		program_coefs(cal);
		queue_directed();
		queue_samples(PHASE_ITEMS);
		settle();

		// every word at its positive limit
		cal = '{24'h00FFFF, 24'h007FFF, 24'h007FFF, 24'h0000FF, 24'h007FFF, 24'h0000FF,
			24'h7FF7FF, 24'h00007F};
		program_coefs(cal);
		queue_samples(PHASE_ITEMS);
		settle();

		// every word at its negative limit or zero
		cal = '{24'h000000, 24'h008000, 24'h008000, 24'h000000, 24'h008000, 24'h000000,
			24'h800800, 24'h000080};
		program_coefs(cal);
		queue_samples(PHASE_ITEMS);
		settle();

		// all data bits set: upper bits beyond each register width must be dropped
		cal = '{default: '1};
		program_coefs(cal);
		queue_samples(PHASE_ITEMS);
		settle();

		for (int k = 0; k < JITTER_SETS; k++) begin
			cal[REG_TEMP_COEF_ONE] = jitter(27504, 3000) & 24'h00FFFF;
			cal[REG_TEMP_COEF_TWO] = jitter(26435, 4000) & 24'h00FFFF;
			cal[REG_TEMP_COEF_THREE] = jitter(-1000, 3000) & 24'h00FFFF;
			cal[REG_HUM_COEF_ONE] = CFG_DATA_W'($urandom_range(0, 255));
			cal[REG_HUM_COEF_TWO] = jitter(362, 200) & 24'h00FFFF;
			cal[REG_HUM_COEF_THREE] = CFG_DATA_W'($urandom_range(0, 255));
			cal[REG_HUM_COEF_FOUR_FIVE] = {12'(jitter(50, 60)), 12'(jitter(313, 300))};
			cal[REG_HUM_COEF_SIX] = jitter(30, 40) & 24'h0000FF;
			program_coefs(cal);
			queue_samples(PHASE_ITEMS);
			settle();
		end

		for (int k = 0; k < RANDOM_SETS; k++) begin
			foreach (cal[i])
				cal[i] = CFG_DATA_W'($urandom_range(0, 24'hFFFFFF));
			program_coefs(cal);
			queue_samples(PHASE_ITEMS);
			settle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("tb_top: %0d samples sent, %0d readings checked over %0d calibration sets",
			n_samples, n_readings, n_cal_sets);
		$display({"tb_top: skipped temp %0d, skipped humidity %0d, ",
			"humidity clamped %0d low %0d high, %0d mismatches"},
			n_t_skip, n_h_skip, n_h_floor, n_h_ceil, n_mismatch);
		if (n_mismatch == 0 && reading_q.size() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
